/* rtl/core/liquify_warp_source_coord_assert.svh */
// ----------------------------------------------------------------------------
// Liquify warp assertion macros
// Shared concurrent assertion forms for the checker of the warp block.
// ----------------------------------------------------------------------------
`ifndef LIQUIFY_WARP_SOURCE_COORD_ASSERT_SVH
`define LIQUIFY_WARP_SOURCE_COORD_ASSERT_SVH

// Check a property on every clock edge outside reset
`define LIQ_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("liquify warp assertion failed");

// Check a property on every clock edge, reset included
`define LIQ_ASSERT_ALL(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("liquify warp assertion failed");

`endif

/* rtl/core/liq_pkg.sv */
// ----------------------------------------------------------------------------
// Liquify warp package
// Widths, register indexes and shared structs of the warp source block.
// ----------------------------------------------------------------------------
package liq_pkg;

  localparam int FRAC_BITS = 4;
  localparam int MAX_DIM   = 4096;
  localparam int PT_W      = 16;   // Q12.4 point
  localparam int CRD_W     = 12;   // pixel coordinate
  localparam int OFF_W     = 26;   // byte offset
  localparam int DIM_W     = 13;   // image size register
  localparam int RAD_W     = 10;
  localparam int DIF_W     = PT_W + 1;        // signed difference
  localparam int SQ_W      = 2 * PT_W + 1;    // one squared difference
  localparam int R2_W      = 2 * (RAD_W + FRAC_BITS);
  localparam int M_W       = SQ_W + 1;
  localparam int NUM_W     = R2_W + 16;
  localparam int DEN_W     = M_W + 1;
  localparam int QB        = 17;              // quotient bits, t <= 2^16
  localparam int STR_W     = 14;              // row stride in bytes
  localparam int PRD_W     = DIF_W + 17;      // weight times difference

  typedef enum logic [2:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_END_X   = 3'd2,
    CFG_END_Y   = 3'd3,
    CFG_RADIUS  = 3'd4,
    CFG_WIDTH   = 3'd5,
    CFG_HEIGHT  = 3'd6
  } cfg_idx_t;

  // Values derived from the registers, used along the pipeline
  typedef struct packed {
    logic [PT_W-1:0]         start_x;
    logic [PT_W-1:0]         start_y;
    logic [PT_W-1:0]         end_x;
    logic [PT_W-1:0]         end_y;
    logic signed [DIF_W-1:0] cmx;
    logic signed [DIF_W-1:0] cmy;
    logic [M_W-1:0]          m;
    logic [R2_W-1:0]         r2;
    logic [CRD_W-1:0]        wmax;
    logic [CRD_W-1:0]        hmax;
    logic [STR_W-1:0]        stride;
  } cfg_t;

  // Side data that rides through the divider
  typedef struct packed {
    logic            warp;
    logic [PT_W-1:0] px;
    logic [PT_W-1:0] py;
  } side_t;

endpackage

/* rtl/core/liq_cfg.sv */
// ----------------------------------------------------------------------------
// Liquify warp configuration
// Register file and the values derived from it (drag vector, radius, stride).
// ----------------------------------------------------------------------------
module liq_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_wdata,
  output liq_pkg::cfg_t          cfg
);
  import liq_pkg::*;

  logic [PT_W-1:0]  start_x_r, start_y_r, end_x_r, end_y_r;
  logic [RAD_W-1:0] radius_r;
  logic [DIM_W-1:0] width_r, height_r;

  logic signed [DIF_W-1:0] cmx_r, cmy_r;
  logic signed [2*DIF_W-1:0] sqx_nxt, sqy_nxt;
  logic [SQ_W-1:0]  sqx_r, sqy_r;
  logic [M_W-1:0]   m_r;
  logic [R2_W-1:0]  rq;
  logic [R2_W-1:0]  r2_r;
  logic [DIM_W-1:0] wd, hd;
  logic [DIM_W-1:0] wmax_full, hmax_full;
  logic [STR_W+1:0] str_sum;
  logic [CRD_W-1:0] wmax_r, hmax_r;
  logic [STR_W-1:0] stride_r;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
      radius_r  <= RAD_W'(100);
      width_r   <= DIM_W'(640);
      height_r  <= DIM_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_X: start_x_r <= cfg_wdata[PT_W-1:0];
        CFG_START_Y: start_y_r <= cfg_wdata[PT_W-1:0];
        CFG_END_X:   end_x_r   <= cfg_wdata[PT_W-1:0];
        CFG_END_Y:   end_y_r   <= cfg_wdata[PT_W-1:0];
        CFG_RADIUS:  radius_r  <= cfg_wdata[RAD_W-1:0];
        CFG_WIDTH:   width_r   <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT:  height_r  <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit image size to 1..MAX_DIM
  always_comb begin
    wd = width_r;
    if (width_r == '0) wd = DIM_W'(1);
    else if (width_r > DIM_W'(MAX_DIM)) wd = DIM_W'(MAX_DIM);
    hd = height_r;
    if (height_r == '0) hd = DIM_W'(1);
    else if (height_r > DIM_W'(MAX_DIM)) hd = DIM_W'(MAX_DIM);
    wmax_full = wd - DIM_W'(1);
    hmax_full = hd - DIM_W'(1);
    // 3 bytes per pixel, row rounded up to 4 bytes
    str_sum   = (STR_W+2)'(3) * (STR_W+2)'(wd) + (STR_W+2)'(3);
  end

  assign sqx_nxt = cmx_r * cmx_r;
  assign sqy_nxt = cmy_r * cmy_r;
  // Radius in Q.4, widened so its square keeps every bit
  assign rq      = R2_W'({radius_r, FRAC_BITS'(0)});

  // Derive drag vector, its squared length and r^2 in registered steps
  always_ff @(posedge clk) begin
    cmx_r    <= $signed({1'b0, end_x_r}) - $signed({1'b0, start_x_r});
    cmy_r    <= $signed({1'b0, end_y_r}) - $signed({1'b0, start_y_r});
    sqx_r    <= sqx_nxt[SQ_W-1:0];
    sqy_r    <= sqy_nxt[SQ_W-1:0];
    m_r      <= M_W'(sqx_r) + M_W'(sqy_r);
    r2_r     <= rq * rq;
    wmax_r   <= wmax_full[CRD_W-1:0];
    hmax_r   <= hmax_full[CRD_W-1:0];
    stride_r <= {str_sum[STR_W-1:2], 2'b00};
  end

  assign cfg.start_x = start_x_r;
  assign cfg.start_y = start_y_r;
  assign cfg.end_x   = end_x_r;
  assign cfg.end_y   = end_y_r;
  assign cfg.cmx     = cmx_r;
  assign cfg.cmy     = cmy_r;
  assign cfg.m       = m_r;
  assign cfg.r2      = r2_r;
  assign cfg.wmax    = wmax_r;
  assign cfg.hmax    = hmax_r;
  assign cfg.stride  = stride_r;

endmodule

/* rtl/core/liq_div.sv */
// ----------------------------------------------------------------------------
// Liquify warp divider
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module liq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [liq_pkg::NUM_W-1:0]   num,
  input  logic [liq_pkg::DEN_W-1:0]   den,
  input  liq_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [liq_pkg::QB-1:0]      quo,
  output liq_pkg::side_t              out_side
);
  import liq_pkg::*;

  localparam int TW = DEN_W + QB;

  logic             vld_r  [QB];
  logic [NUM_W-1:0] rem_r  [QB];
  logic [DEN_W-1:0] den_r  [QB];
  logic [QB-1:0]    quo_r  [QB];
  side_t            side_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [QB-1:0]    q_in;
    side_t            s_in;
    logic [TW-1:0]    trial;

    if (j == 0) begin : g_first
      assign v_in = in_vld;
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld_r[j-1];
      assign r_in = rem_r[j-1];
      assign d_in = den_r[j-1];
      assign q_in = quo_r[j-1];
      assign s_in = side_r[j-1];
    end

    // Try to subtract the shifted divisor
    assign trial = TW'(r_in) - (TW'(d_in) << (QB - 1 - j));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[j]  <= d_in;
        side_r[j] <= s_in;
        if (!trial[TW-1]) begin
          rem_r[j] <= trial[NUM_W-1:0];
          quo_r[j] <= {q_in[QB-2:0], 1'b1};
        end else begin
          rem_r[j] <= r_in;
          quo_r[j] <= {q_in[QB-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[QB-1];
  assign quo      = quo_r[QB-1];
  assign out_side = side_r[QB-1];

endmodule

/* rtl/core/liquify_warp_source_coord.sv */
// ----------------------------------------------------------------------------
// Liquify warp source coordinate
// Maps an output pixel to the source pixel of a local translation warp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one output pixel (in_out_x,
//   in_out_y). The result channel out_valid/out_stall returns the source
//   pixel, its byte offset in a 24-bit row-padded image and a warped flag.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) sets the drag
//   points, radius and image size; write it only while no item is in flight.
//   The item passes 25 register stages: four distance stages, a 17-stage
//   divider (one quotient bit per stage), a squaring stage, a displacement
//   multiply, a clamp stage and an offset multiply feed the output
//   register. Throughput is one item per cycle while the receiver does not
//   stall.
//   Reset empties the pipeline and loads the register defaults.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_stall rises in the same cycle; nothing is dropped.
// ----------------------------------------------------------------------------
module liquify_warp_source_coord (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [liq_pkg::CRD_W-1:0]  in_out_x,
  input  logic [liq_pkg::CRD_W-1:0]  in_out_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [liq_pkg::CRD_W-1:0]  out_src_x,
  output logic [liq_pkg::CRD_W-1:0]  out_src_y,
  output logic [liq_pkg::OFF_W-1:0]  out_src_offset,
  output logic                       out_warped,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_wdata
);
  import liq_pkg::*;

  localparam int SH  = FRAC_BITS + 16;
  localparam int QXW = PRD_W + 1;

  cfg_t cfg;
  logic adv;

  // stage 1: differences
  logic                    v1_r;
  logic [PT_W-1:0]         px1_r, py1_r;
  logic signed [DIF_W-1:0] dex1_r, dey1_r, dsx1_r, dsy1_r;
  logic [PT_W-1:0]         px_in, py_in;
  // stage 2: squares
  logic                    v2_r;
  logic [PT_W-1:0]         px2_r, py2_r;
  logic [SQ_W-1:0]         sqex2_r, sqey2_r, sqsx2_r, sqsy2_r;
  logic signed [2*DIF_W-1:0] sqex, sqey, sqsx, sqsy;
  // stage 3: circle tests
  logic                    v3_r, warp3_r;
  logic [PT_W-1:0]         px3_r, py3_r;
  logic [R2_W-1:0]         e3_r;
  logic [M_W-1:0]          dend, dst;
  // stage 4: divider operands
  logic                    v4_r;
  side_t                   side4_r;
  logic [NUM_W-1:0]        num4_r;
  logic [DEN_W-1:0]        den4_r;
  // divider output
  logic                    v5;
  logic [QB-1:0]           q5;
  side_t                   side5;
  // stage 6: weight
  logic                    v6_r;
  side_t                   side6_r;
  logic [15:0]             a6_r;
  logic [15:0]             t5;
  logic [31:0]             tt;
  // stage 7: displacement
  logic                    v7_r;
  side_t                   side7_r;
  logic signed [PRD_W-1:0] prx7_r, pry7_r;
  // stage 8: clamp
  logic                    v8_r, warp8_r;
  logic [CRD_W-1:0]        ux8_r, uy8_r;
  logic signed [QXW-1:0]   qx, qy;
  // output
  logic                    out_valid_r, warped_r;
  logic [CRD_W-1:0]        src_x_r, src_y_r;
  logic [OFF_W-1:0]        off_r;
  logic [CRD_W+STR_W-1:0]  row_off;

  // Clamp a Q(frac+16) value to 0..mx and floor it
  function automatic logic [CRD_W-1:0] clamp_floor(input logic signed [QXW-1:0] q,
                                                   input logic [CRD_W-1:0] mx);
    logic [QXW-SH-1:0] fl;
    begin
      fl = q[QXW-1:SH];
      if (q[QXW-1])
        clamp_floor = '0;
      else if (fl > (QXW-SH)'(mx))
        clamp_floor = mx;
      else
        clamp_floor = fl[CRD_W-1:0];
    end
  endfunction

  liq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance all stages unless a result waits on a stalled receiver
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign px_in = {in_out_x, FRAC_BITS'(0)};
  assign py_in = {in_out_y, FRAC_BITS'(0)};

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v6_r        <= v5;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      out_valid_r <= v8_r;
    end
  end

  assign sqex = dex1_r * dex1_r;
  assign sqey = dey1_r * dey1_r;
  assign sqsx = dsx1_r * dsx1_r;
  assign sqsy = dsy1_r * dsy1_r;
  assign dend = M_W'(sqex2_r) + M_W'(sqey2_r);
  assign dst  = M_W'(sqsx2_r) + M_W'(sqsy2_r);

  // Front stages: differences, squares, circle tests, divider operands
  always_ff @(posedge clk) begin
    if (adv) begin
      px1_r   <= px_in;
      py1_r   <= py_in;
      dex1_r  <= $signed({1'b0, px_in}) - $signed({1'b0, cfg.end_x});
      dey1_r  <= $signed({1'b0, py_in}) - $signed({1'b0, cfg.end_y});
      dsx1_r  <= $signed({1'b0, px_in}) - $signed({1'b0, cfg.start_x});
      dsy1_r  <= $signed({1'b0, py_in}) - $signed({1'b0, cfg.start_y});

      px2_r   <= px1_r;
      py2_r   <= py1_r;
      sqex2_r <= sqex[SQ_W-1:0];
      sqey2_r <= sqey[SQ_W-1:0];
      sqsx2_r <= sqsx[SQ_W-1:0];
      sqsy2_r <= sqsy[SQ_W-1:0];

      px3_r   <= px2_r;
      py3_r   <= py2_r;
      warp3_r <= (dend < M_W'(cfg.r2)) && (dst < M_W'(cfg.r2));
      e3_r    <= cfg.r2 - dst[R2_W-1:0];

      side4_r.warp <= warp3_r;
      side4_r.px   <= px3_r;
      side4_r.py   <= py3_r;
      num4_r  <= {e3_r, 16'h0000};
      den4_r  <= DEN_W'(e3_r) + DEN_W'(cfg.m);
    end
  end

  liq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v4_r),
    .num      (num4_r),
    .den      (den4_r),
    .in_side  (side4_r),
    .out_vld  (v5),
    .quo      (q5),
    .out_side (side5)
  );

  // Saturate the ratio and square it
  assign t5 = q5[QB-1] ? 16'hFFFF : q5[15:0];
  assign tt = t5 * t5;

  assign qx = $signed({3'b000, side7_r.px, 16'h0000}) - $signed({prx7_r[PRD_W-1], prx7_r});
  assign qy = $signed({3'b000, side7_r.py, 16'h0000}) - $signed({pry7_r[PRD_W-1], pry7_r});

  assign row_off = uy8_r * cfg.stride;

  // Back stages: weight, displacement, clamp, offset
  always_ff @(posedge clk) begin
    if (adv) begin
      side6_r <= side5;
      a6_r    <= tt[31:16];

      side7_r <= side6_r;
      if (side6_r.warp) begin
        prx7_r <= $signed({1'b0, a6_r}) * cfg.cmx;
        pry7_r <= $signed({1'b0, a6_r}) * cfg.cmy;
      end else begin
        prx7_r <= '0;
        pry7_r <= '0;
      end

      warp8_r <= side7_r.warp;
      ux8_r   <= clamp_floor(qx, cfg.wmax);
      uy8_r   <= clamp_floor(qy, cfg.hmax);

      warped_r <= warp8_r;
      src_x_r  <= ux8_r;
      src_y_r  <= uy8_r;
      off_r    <= OFF_W'(row_off) + OFF_W'(OFF_W'(3) * OFF_W'(ux8_r));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_src_x      = src_x_r;
  assign out_src_y      = src_y_r;
  assign out_src_offset = off_r;
  assign out_warped     = warped_r;

endmodule

/* rtl/core/liq_chk.sv */
// ----------------------------------------------------------------------------
// Liquify warp checker
// Port-level assertions on the warp block, attached by bind.
// ----------------------------------------------------------------------------
`include "liquify_warp_source_coord_assert.svh"

module liq_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [liq_pkg::CRD_W-1:0]  out_src_x,
  input logic [liq_pkg::CRD_W-1:0]  out_src_y,
  input logic [liq_pkg::OFF_W-1:0]  out_src_offset,
  input logic                       out_warped
);
  import liq_pkg::*;

  // Reset empties the result register
  `LIQ_ASSERT_ALL(a_rst_empty, clk, (!rst_n |=> !out_valid))

  // Input backs up only behind a waiting, stalled result
  `LIQ_ASSERT(a_in_stall, clk, rst_n, (in_stall == (out_valid && out_stall)))

  // Hold a stalled result
  `LIQ_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall |=> out_valid && $stable(out_src_x) && $stable(out_src_y) && $stable(out_src_offset) && $stable(out_warped)))

  // Offset never falls below the column bytes of the result
  `LIQ_ASSERT(a_off_min, clk, rst_n, (out_valid |-> (out_src_offset >= (OFF_W'(3) * OFF_W'(out_src_x)))))

endmodule

bind liquify_warp_source_coord liq_chk u_liq_chk (.*);
